@@ hdl/tbpd_pkg.sv @@
// ----------------------------------------------------------------------------
// tbpd_pkg
// Shared types, constants and shape tables for the tile block pixel decoder.
// ----------------------------------------------------------------------------
package tbpd_pkg;

  localparam int COORD_BITS = 16;
  localparam int LEFT_BITS  = 18;
  localparam int IN_BITS    = 88;
  localparam int OUT_BITS   = 40;

  localparam logic [15:0] DIAMOND_FORMAT = 16'h0001;
  localparam logic [4:0]  DIAMOND_ROWS   = 5'd15;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_COUNT,
    PH_LIT
  } phase_t;

  typedef struct packed {
    logic                 diamond_mode;
    logic [LEFT_BITS-1:0] bytes_left;
    coord_t               origin_x;
    coord_t               origin_y;
    coord_t               cursor_x;
    coord_t               cursor_y;
    phase_t               pair_phase;
    logic [7:0]           held_skip;
    logic [7:0]           run_left;
    logic [5:0]           row_left;
  } dec_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [15:0] block_x;
    logic [15:0] block_y;
    logic [15:0] block_format;
    logic [15:0] block_length;
    logic [14:0] tile_y_offset;
  } item_t;

  // diamond row start column
  function automatic logic [4:0] row_start(input logic [3:0] row);
    logic [4:0] v;
    case (row)
      4'd0, 4'd14: v = 5'd14;
      4'd1, 4'd13: v = 5'd12;
      4'd2, 4'd12: v = 5'd10;
      4'd3, 4'd11: v = 5'd8;
      4'd4, 4'd10: v = 5'd6;
      4'd5, 4'd9:  v = 5'd4;
      4'd6, 4'd8:  v = 5'd2;
      default:     v = 5'd0;
    endcase
    return v;
  endfunction

  // diamond row width in pixels
  function automatic logic [5:0] row_width(input logic [3:0] row);
    logic [5:0] v;
    case (row)
      4'd0, 4'd14: v = 6'd4;
      4'd1, 4'd13: v = 6'd8;
      4'd2, 4'd12: v = 6'd12;
      4'd3, 4'd11: v = 6'd16;
      4'd4, 4'd10: v = 6'd20;
      4'd5, 4'd9:  v = 6'd24;
      4'd6, 4'd8:  v = 6'd28;
      4'd7:        v = 6'd32;
      default:     v = 6'd4;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/iso_tile_block_pixel_decoder_core.sv @@
// ----------------------------------------------------------------------------
// iso_tile_block_pixel_decoder_core
// Turns header and colormap byte items into pixel writes (column, row, index).
// ----------------------------------------------------------------------------
// Output: a pixel appears on the output register in the cycle after its byte.
// Throughput: one item per cycle; input stalls only while a pixel waits
// unread in the output register and m_tready is low.
// Reset: synchronous rst clears the decoder state (block idle) and empties
// the output register.
module iso_tile_block_pixel_decoder_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // data_byte, block_x, block_y, block_format, block_length, tile_y_offset, 0
  input  logic [tbpd_pkg::IN_BITS-1:0]  s_tdata,
  // kind
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pixel_x, pixel_y, color_index
  output logic [tbpd_pkg::OUT_BITS-1:0] m_tdata
);
  import tbpd_pkg::*;

  dec_state_t  state;
  dec_state_t  state_next;
  item_t       item;
  logic        emit;
  logic        accept;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [7:0]  color_index;

  assign item.kind          = s_tuser;
  assign item.data_byte     = s_tdata[7:0];
  assign item.block_x       = s_tdata[23:8];
  assign item.block_y       = s_tdata[39:24];
  assign item.block_format  = s_tdata[55:40];
  assign item.block_length  = s_tdata[71:56];
  assign item.tile_y_offset = s_tdata[86:72];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  tbpd_step u_step (
    .state       (state),
    .item        (item),
    .state_next  (state_next),
    .emit        (emit),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .color_index (color_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_tdata <= {color_index, pixel_y, pixel_x};
    end
  end

endmodule

@@ hdl/tbpd_step.sv @@
// ----------------------------------------------------------------------------
// tbpd_step
// Next-state and pixel logic for one item: header load, diamond walk and
// skip/run pair decoding.
// ----------------------------------------------------------------------------
module tbpd_step (
  input  tbpd_pkg::dec_state_t state,
  input  tbpd_pkg::item_t      item,
  output tbpd_pkg::dec_state_t state_next,
  output logic                 emit,
  output logic [15:0]          pixel_x,
  output logic [15:0]          pixel_y,
  output logic [7:0]           color_index
);
  import tbpd_pkg::*;

  logic signed [31:0] by_wide;
  logic [5:0]         rl_dec;
  logic [7:0]         run_dec;
  coord_t             cy_inc;
  coord_t             sum_x;
  coord_t             sum_y;

  assign sum_x       = state.origin_x + state.cursor_x;
  assign sum_y       = state.origin_y + state.cursor_y;
  assign pixel_x     = 16'(sum_x);
  assign pixel_y     = 16'(sum_y);
  assign color_index = item.data_byte;

  assign rl_dec  = (state.row_left != 6'd0) ? state.row_left - 6'd1 : 6'd0;
  assign run_dec = (state.run_left != 8'd0) ? state.run_left - 8'd1 : 8'd0;
  assign cy_inc  = state.cursor_y + coord_t'(1);

  always_comb begin
    by_wide = 32'(signed'(item.block_y));
    if (item.block_y[15]) begin
      by_wide = by_wide + {17'd0, item.tile_y_offset};
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    if (item.kind == KIND_HEADER) begin
      state_next.origin_x     = coord_t'(32'(signed'(item.block_x)));
      state_next.origin_y     = by_wide[COORD_BITS-1:0];
      state_next.diamond_mode = (item.block_format == DIAMOND_FORMAT);
      state_next.bytes_left   = LEFT_BITS'(item.block_length);
      state_next.pair_phase   = PH_SKIP;
      state_next.held_skip    = 8'd0;
      state_next.run_left     = 8'd0;
      state_next.cursor_y     = '0;
      if (item.block_format == DIAMOND_FORMAT) begin
        state_next.cursor_x = coord_t'(row_start(4'd0));
        state_next.row_left = row_width(4'd0);
      end else begin
        state_next.cursor_x = '0;
        state_next.row_left = 6'd0;
      end
    end else if (state.bytes_left != '0) begin
      state_next.bytes_left = state.bytes_left - LEFT_BITS'(1);
      if (state.diamond_mode) begin
        emit                = 1'b1;
        state_next.cursor_x = state.cursor_x + coord_t'(1);
        state_next.row_left = rl_dec;
        if (rl_dec == 6'd0) begin
          state_next.cursor_y = cy_inc;
          if (cy_inc >= coord_t'(DIAMOND_ROWS)) begin
            state_next.bytes_left = '0;
          end else begin
            state_next.cursor_x = coord_t'(row_start(cy_inc[3:0]));
            state_next.row_left = row_width(cy_inc[3:0]);
          end
        end
      end else begin
        case (state.pair_phase)
          PH_SKIP: begin
            state_next.held_skip  = item.data_byte;
            state_next.pair_phase = PH_COUNT;
          end
          PH_COUNT: begin
            if (state.held_skip == 8'd0 && item.data_byte == 8'd0) begin
              state_next.cursor_x   = '0;
              state_next.cursor_y   = cy_inc;
              state_next.pair_phase = PH_SKIP;
            end else begin
              state_next.cursor_x   = state.cursor_x + coord_t'(state.held_skip);
              state_next.run_left   = item.data_byte;
              state_next.pair_phase = (item.data_byte != 8'd0) ? PH_LIT : PH_SKIP;
            end
          end
          PH_LIT: begin
            emit                = 1'b1;
            state_next.cursor_x = state.cursor_x + coord_t'(1);
            state_next.run_left = run_dec;
            if (run_dec == 8'd0) begin
              state_next.pair_phase = PH_SKIP;
            end
          end
          default: begin
            state_next.pair_phase = PH_SKIP;
          end
        endcase
      end
    end
  end

endmodule

@@ sim/tb_iso_tile_block_pixel_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iso_tile_block_pixel_decoder_core
// Self-checking bench for the tile block pixel decoder. A short table of
// header and byte items covers the field extremes, both block formats, idle
// bytes, zero-length, cut-short and abandoned blocks. Random blocks follow,
// mostly well-formed diamonds and skip/run streams, plus noise. Each pixel
// write is checked field by field against a built-in decoder model, under
// several source-idle and sink-stall mixes and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_iso_tile_block_pixel_decoder_core;
  import tbpd_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 213;

  typedef struct packed {
    coord_t     x;
    coord_t     y;
    logic [7:0] c;
  } pix_t;

  typedef struct {
    item_t it;
    bit    typed;
    pix_t  want;
  } dir_row_t;

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;

  // decoder model state
  logic                 dm_diamond;
  logic [LEFT_BITS-1:0] dm_left;
  coord_t               dm_org_x, dm_org_y, dm_cur_x, dm_cur_y;
  phase_t               dm_phase;
  logic [7:0]           dm_skip, dm_run;
  logic [5:0]           dm_row_left;

  pix_t     pixel_q[$];
  dir_row_t dir_tab[$];
  int       err_cnt    = 0;
  int       used_cnt   = 0;
  int       idle_pct   = 0;
  int       stall_pct  = 0;
  int       rx_hold    = 0;
  int       quiet_cnt  = 0;

  iso_tile_block_pixel_decoder_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // diamond row r starts 2*|r-7| columns in; its width is 32 minus twice that
  function automatic coord_t dia_start(input coord_t row);
    coord_t d;
    d = (row > coord_t'(7)) ? row - coord_t'(7) : coord_t'(7) - row;
    return d << 1;
  endfunction

  function automatic void add_row(input dir_row_t r);
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  task automatic decode_item(input item_t it, output bit used, output bit has_pix,
                             output pix_t px);
    coord_t by;
    used    = 1'b1;
    has_pix = 1'b0;
    px      = '0;
    if (it.kind == KIND_HEADER) begin
      by = it.block_y;
      if (by[15]) by = by + coord_t'(it.tile_y_offset);
      dm_org_x   = it.block_x;
      dm_org_y   = by;
      dm_diamond = (it.block_format == DIAMOND_FORMAT);
      dm_left    = LEFT_BITS'(it.block_length);
      dm_phase   = PH_SKIP;
      dm_skip    = '0;
      dm_run     = '0;
      dm_cur_y   = '0;
      if (dm_diamond) begin
        dm_cur_x    = dia_start('0);
        dm_row_left = 6'(32 - 2 * dia_start('0));
      end else begin
        dm_cur_x    = '0;
        dm_row_left = '0;
      end
    end else if (dm_left == 0) begin
      used = 1'b0;
    end else begin
      dm_left = dm_left - LEFT_BITS'(1);
      if (dm_diamond) begin
        has_pix  = 1'b1;
        px.x     = dm_org_x + dm_cur_x;
        px.y     = dm_org_y + dm_cur_y;
        px.c     = it.data_byte;
        dm_cur_x = dm_cur_x + coord_t'(1);
        if (dm_row_left != 0) dm_row_left = dm_row_left - 6'd1;
        if (dm_row_left == 0) begin
          dm_cur_y = dm_cur_y + coord_t'(1);
          if (dm_cur_y >= coord_t'(DIAMOND_ROWS)) begin
            dm_left = '0;
          end else begin
            dm_cur_x    = dia_start(dm_cur_y);
            dm_row_left = 6'(32 - 2 * dia_start(dm_cur_y));
          end
        end
      end else if (dm_phase == PH_SKIP) begin
        dm_skip  = it.data_byte;
        dm_phase = PH_COUNT;
      end else if (dm_phase == PH_COUNT) begin
        if (dm_skip == 0 && it.data_byte == 0) begin
          dm_cur_x = '0;
          dm_cur_y = dm_cur_y + coord_t'(1);
          dm_phase = PH_SKIP;
        end else begin
          dm_cur_x = dm_cur_x + coord_t'(dm_skip);
          dm_run   = it.data_byte;
          dm_phase = (it.data_byte != 0) ? PH_LIT : PH_SKIP;
        end
      end else begin
        has_pix  = 1'b1;
        px.x     = dm_org_x + dm_cur_x;
        px.y     = dm_org_y + dm_cur_y;
        px.c     = it.data_byte;
        dm_cur_x = dm_cur_x + coord_t'(1);
        if (dm_run != 0) dm_run = dm_run - 8'd1;
        if (dm_run == 0) dm_phase = PH_SKIP;
      end
    end
  endtask

  function automatic item_t mk_hdr(input logic [15:0] bx, input logic [15:0] by,
                                   input logic [15:0] fmt, input logic [15:0] len,
                                   input logic [14:0] yoff);
    item_t it;
    it               = '0;
    it.kind          = KIND_HEADER;
    it.block_x       = bx;
    it.block_y       = by;
    it.block_format  = fmt;
    it.block_length  = len;
    it.tile_y_offset = yoff;
    return it;
  endfunction

  function automatic item_t mk_byte(input logic [7:0] b);
    item_t it;
    it           = '0;
    it.kind      = KIND_DATA;
    it.data_byte = b;
    return it;
  endfunction

  function automatic dir_row_t row_plain(input item_t it);
    dir_row_t r;
    r.it    = it;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic dir_row_t row_pix(input logic [7:0] b, input coord_t x, input coord_t y);
    dir_row_t r;
    r.it     = mk_byte(b);
    r.typed  = 1'b1;
    r.want.x = x;
    r.want.y = y;
    r.want.c = b;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input item_t it, input bit typed, input pix_t want);
    bit   used, has_pix;
    pix_t px;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {1'b0, it.tile_y_offset, it.block_length, it.block_format,
                 it.block_y, it.block_x, it.data_byte};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_item(it, used, has_pix, px);
    if (used) used_cnt++;
    if (typed) pixel_q.insert(pixel_q.size(), want);
    else if (has_pix) pixel_q.insert(pixel_q.size(), px);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_block();
    item_t      hdr;
    logic [7:0] bytes[$];
    bit         send_hdr;
    int         n, sel, k, cnt;
    logic [7:0] skp;
    send_hdr = 1'b1;
    hdr = mk_hdr(16'($urandom), 16'($urandom), '0, '0, 15'($urandom_range(0, 32767)));
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      hdr.block_format = DIAMOND_FORMAT;
      k = $urandom_range(0, 99);
      if (k < 55) n = 256;
      else if (k < 70) n = 256 + $urandom_range(1, 20);
      else n = $urandom_range(1, 255);
      hdr.block_length = (k >= 92) ? 16'($urandom) : 16'(n);
      repeat (n) bytes.insert(bytes.size(), 8'($urandom));
    end else if (sel < 93) begin
      hdr.block_format = 16'($urandom);
      if (hdr.block_format == DIAMOND_FORMAT) hdr.block_format = '0;
      repeat ($urandom_range(1, 8)) begin
        k = $urandom_range(0, 99);
        if (k < 15) begin
          bytes.insert(bytes.size(), 8'd0);
          bytes.insert(bytes.size(), 8'd0);
        end else if (k < 28) begin
          bytes.insert(bytes.size(), 8'($urandom_range(1, 255)));
          bytes.insert(bytes.size(), 8'd0);
        end else begin
          skp = (k < 90) ? 8'($urandom_range(0, 12)) : 8'($urandom);
          cnt = (k < 97) ? $urandom_range(1, 6) : $urandom_range(1, 255);
          bytes.insert(bytes.size(), skp);
          bytes.insert(bytes.size(), 8'(cnt));
          repeat (cnt) bytes.insert(bytes.size(), 8'($urandom));
        end
      end
      n = bytes.size();
      k = $urandom_range(0, 99);
      if (k < 75) hdr.block_length = 16'(n);
      else if (k < 88) hdr.block_length = 16'($urandom_range(0, n - 1));
      else hdr.block_length = 16'($urandom_range(n, 65535));
    end else begin
      hdr.block_format = 16'($urandom);
      hdr.block_length = 16'($urandom);
      send_hdr = $urandom_range(0, 1);
      repeat ($urandom_range(1, 6)) bytes.insert(bytes.size(), 8'($urandom));
    end
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) bytes.insert(bytes.size(), 8'($urandom));
    if (send_hdr) send_item(hdr, 1'b0, '0);
    foreach (bytes[i]) send_item(mk_byte(bytes[i]), 1'b0, '0);
  endtask

  // sink side: random stalls, or a counted hold-off when requested
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    pix_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected pixel, expected none, actual x=%h y=%h c=%h",
                 $time, m_tdata[15:0], m_tdata[31:16], m_tdata[39:32]);
      end else begin
        want = pixel_q.pop_front();
        if (m_tdata[15:0] !== want.x) begin
          err_cnt++;
          $display("%0t: pixel_x mismatch, expected %h, actual %h",
                   $time, want.x, m_tdata[15:0]);
        end
        if (m_tdata[31:16] !== want.y) begin
          err_cnt++;
          $display("%0t: pixel_y mismatch, expected %h, actual %h",
                   $time, want.y, m_tdata[31:16]);
        end
        if (m_tdata[39:32] !== want.c) begin
          err_cnt++;
          $display("%0t: color_index mismatch, expected %h, actual %h",
                   $time, want.c, m_tdata[39:32]);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= STALL_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, quiet_cnt);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    int  base;
    bit  held;
    dm_diamond = 1'b0;
    dm_left    = '0;
    dm_org_x   = '0;
    dm_org_y   = '0;
    dm_cur_x   = '0;
    dm_cur_y   = '0;
    dm_phase   = PH_SKIP;
    dm_skip    = '0;
    dm_run     = '0;
    dm_row_left = '0;
    held = 1'b0;

    // idle byte, skip/run at the extremes, diamond short, zero length,
    // count of zero, cut-short run, abandoned block
    add_row(row_plain(mk_byte(8'hFF)));
    add_row(row_plain(mk_hdr(16'h7FFF, 16'h8000, 16'hFFFF, 16'd6, 15'h7FFF)));
    add_row(row_plain(mk_byte(8'h00)));
    add_row(row_plain(mk_byte(8'h02)));
    add_row(row_pix(8'hFF, 16'h7FFF, 16'hFFFF));
    add_row(row_pix(8'h00, 16'h8000, 16'hFFFF));
    add_row(row_plain(mk_byte(8'h00)));
    add_row(row_plain(mk_byte(8'h00)));
    add_row(row_plain(mk_byte(8'hAA)));
    add_row(row_plain(mk_hdr(16'h8000, 16'h7FFF, DIAMOND_FORMAT, 16'd3, 15'h7FFF)));
    add_row(row_pix(8'h11, 16'h800E, 16'h7FFF));
    add_row(row_plain(mk_byte(8'h22)));
    add_row(row_plain(mk_byte(8'h33)));
    add_row(row_plain(mk_byte(8'h44)));
    add_row(row_plain(mk_hdr('0, '0, '0, '0, '0)));
    add_row(row_plain(mk_byte(8'h55)));
    add_row(row_plain(mk_hdr('0, 16'hFFFF, 16'h0002, 16'd5, '0)));
    add_row(row_plain(mk_byte(8'hFF)));
    add_row(row_plain(mk_byte(8'h00)));
    add_row(row_plain(mk_byte(8'h03)));
    add_row(row_plain(mk_byte(8'h05)));
    add_row(row_pix(8'h77, 16'h0102, 16'hFFFF));
    add_row(row_plain(mk_hdr(16'h0010, 16'hFFF0, 16'h8000, 16'hFFFF, 15'h0020)));
    add_row(row_plain(mk_byte(8'h05)));
    add_row(row_plain(mk_hdr('0, '0, DIAMOND_FORMAT, 16'h0100, '0)));
    add_row(row_pix(8'h00, 16'd14, 16'd0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      base = used_cnt;
      while (used_cnt - base < PHASE_ITEMS) begin
        if (ph == 0 && !held && used_cnt - base >= 60) begin
          rx_hold = HOLD_CYCLES;
          held    = 1'b1;
        end
        if (ph == 2 && used_cnt - base >= PHASE_ITEMS / 2 && held) begin
          wait_drained();
          held = 1'b0;
        end
        random_block();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (err_cnt == 0 && pixel_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
